/* rtl/core/blkc_pkg.sv */
// ----------------------------------------------------------------------------
// blkc_pkg
// Shared constants and types of the block cache tag table.
// ----------------------------------------------------------------------------
package blkc_pkg;

    localparam int ENTRIES = 32;
    localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

    localparam logic [1:0] OP_ACQUIRE = 2'd0;
    localparam logic [1:0] OP_RELEASE = 2'd1;
    localparam logic [1:0] OP_PIN     = 2'd2;
    localparam logic [1:0] OP_UNPIN   = 2'd3;

    localparam logic [1:0] STS_OK     = 2'd0;
    localparam logic [1:0] STS_NOFREE = 2'd1;
    localparam logic [1:0] STS_UNDER  = 2'd2;
    localparam logic [1:0] STS_OVER   = 2'd3;

    localparam logic [31:0] STAMP_NEVER = 32'hffff_ffff;
    localparam logic [7:0]  COUNT_MAX   = 8'hff;

    // Search token that walks down the row of entry cells.
    typedef struct packed {
        logic             vld;
        logic [1:0]       op;
        logic [7:0]       dev;
        logic [31:0]      blk;
        logic [4:0]       slot;
        logic [31:0]      tick;
        logic             hit;
        logic [IDX_W-1:0] hit_idx;
        logic [7:0]       hit_cnt;
        logic             hit_vld;
        logic             cand;
        logic [31:0]      best_stamp;
        logic [IDX_W-1:0] best_idx;
        logic [7:0]       sel_cnt;
    } tok_t;

    // Write command broadcast to all cells once a search is complete.
    typedef struct packed {
        logic             en;
        logic [IDX_W-1:0] idx;
        logic             wr_tag;
        logic             wr_cnt;
        logic             wr_stamp;
        logic             set_vld;
        logic [7:0]       dev;
        logic [31:0]      blk;
        logic [7:0]       cnt;
        logic [31:0]      stamp;
    } upd_t;

    typedef struct packed {
        logic [4:0] slot;
        logic       hit;
        logic       need;
        logic [1:0] status;
        logic [7:0] cnt;
    } res_t;

endpackage

/* rtl/core/blkc_if.sv */
// ----------------------------------------------------------------------------
// blkc_in_if / blkc_out_if
// Valid/ready channels carrying requests and results of the tag table.
// ----------------------------------------------------------------------------
interface blkc_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  opcode;
    logic [7:0]  device_id;
    logic [31:0] block_number;
    logic [4:0]  slot_in;
    logic [31:0] now_tick;

    modport source (output valid, opcode, device_id, block_number, slot_in, now_tick,
                    input ready);
    modport sink   (input valid, opcode, device_id, block_number, slot_in, now_tick,
                    output ready);
endinterface

interface blkc_out_if;
    logic       valid;
    logic       ready;
    logic [4:0] slot_out;
    logic       hit;
    logic       need_read;
    logic [1:0] status;
    logic [7:0] ref_count_out;

    modport source (output valid, slot_out, hit, need_read, status, ref_count_out,
                    input ready);
    modport sink   (input valid, slot_out, hit, need_read, status, ref_count_out,
                    output ready);
endinterface

/* rtl/core/blkc_cell.sv */
// ----------------------------------------------------------------------------
// blkc_cell
// One tag table entry; folds its entry into the passing search token.
// ----------------------------------------------------------------------------
module blkc_cell (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic [blkc_pkg::IDX_W-1:0] my_idx,
    input  blkc_pkg::tok_t        tok_in,
    input  blkc_pkg::upd_t        upd,
    output blkc_pkg::tok_t        tok_out
);
    import blkc_pkg::*;

    logic [7:0]  dev_reg;
    logic [31:0] blk_reg;
    logic [7:0]  cnt_reg;
    logic [31:0] stamp_reg;
    logic        ent_vld_reg;
    logic        tok_vld_reg;
    tok_t        tok_reg;
    tok_t        tok_next;
    logic        mine;

    assign mine = upd.en && (upd.idx == my_idx);

    always_comb
    begin
        tok_next = tok_in;
        // The first matching slot wins, so later cells leave a hit alone.
        if (!tok_in.hit && dev_reg == tok_in.dev && blk_reg == tok_in.blk)
        begin
            tok_next.hit     = 1'b1;
            tok_next.hit_idx = my_idx;
            tok_next.hit_cnt = cnt_reg;
            tok_next.hit_vld = ent_vld_reg;
        end
        // Strict compare keeps ties at the lowest slot and rejects all-ones.
        if (cnt_reg == 8'd0 && stamp_reg < tok_in.best_stamp)
        begin
            tok_next.cand       = 1'b1;
            tok_next.best_stamp = stamp_reg;
            tok_next.best_idx   = my_idx;
        end
        if (32'(tok_in.slot) == 32'(my_idx))
        begin
            tok_next.sel_cnt = cnt_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dev_reg     <= '0;
            blk_reg     <= '0;
            cnt_reg     <= '0;
            stamp_reg   <= '0;
            ent_vld_reg <= 1'b0;
            tok_vld_reg <= 1'b0;
        end
        else
        begin
            tok_vld_reg <= tok_in.vld;
            if (mine)
            begin
                if (upd.wr_tag)
                begin
                    dev_reg <= upd.dev;
                    blk_reg <= upd.blk;
                end
                if (upd.wr_cnt)
                begin
                    cnt_reg <= upd.cnt;
                end
                if (upd.wr_stamp)
                begin
                    stamp_reg <= upd.stamp;
                end
                if (upd.set_vld)
                begin
                    ent_vld_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        tok_reg <= tok_next;
    end

    always_comb
    begin
        tok_out     = tok_reg;
        tok_out.vld = tok_vld_reg;
    end

endmodule

/* rtl/core/blkc_ctrl.sv */
// ----------------------------------------------------------------------------
// blkc_ctrl
// Launches search tokens, resolves the finished search and holds results.
// ----------------------------------------------------------------------------
module blkc_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    blkc_in_if.sink        in,
    blkc_out_if.source     out,
    output blkc_pkg::tok_t tok_head,
    input  blkc_pkg::tok_t tok_tail,
    output blkc_pkg::upd_t upd
);
    import blkc_pkg::*;

    typedef enum logic [1:0] {S_IDLE, S_SCAN, S_HOLD} state_t;

    state_t state_reg;
    logic   out_vld_reg;
    res_t   out_reg;
    res_t   pend_reg;
    res_t   res;
    logic   done;
    logic   out_free;
    logic   accept;
    logic [7:0] cnt;

    assign accept   = in.valid && in.ready;
    assign in.ready = (state_reg == S_IDLE);
    assign done     = (state_reg == S_SCAN) && tok_tail.vld;
    assign out_free = !out_vld_reg || out.ready;

    always_comb
    begin
        tok_head            = '0;
        tok_head.vld        = accept;
        tok_head.op         = in.opcode;
        tok_head.dev        = in.device_id;
        tok_head.blk        = in.block_number;
        tok_head.slot       = in.slot_in;
        tok_head.tick       = in.now_tick;
        tok_head.best_stamp = STAMP_NEVER;
    end

    always_comb
    begin
        res       = '0;
        upd       = '0;
        upd.dev   = tok_tail.dev;
        upd.blk   = tok_tail.blk;
        upd.stamp = tok_tail.tick;
        cnt       = (tok_tail.op == OP_ACQUIRE) ? tok_tail.hit_cnt : tok_tail.sel_cnt;
        if (tok_tail.op == OP_ACQUIRE)
        begin
            if (tok_tail.hit)
            begin
                upd.idx     = tok_tail.hit_idx;
                upd.set_vld = 1'b1;
                upd.wr_cnt  = (cnt != COUNT_MAX);
                upd.cnt     = cnt + 8'd1;
                res.slot    = 5'(tok_tail.hit_idx);
                res.hit     = 1'b1;
                res.need    = !tok_tail.hit_vld;
                res.status  = (cnt == COUNT_MAX) ? STS_OVER : STS_OK;
                res.cnt     = (cnt == COUNT_MAX) ? COUNT_MAX : cnt + 8'd1;
            end
            else if (tok_tail.cand)
            begin
                upd.idx     = tok_tail.best_idx;
                upd.set_vld = 1'b1;
                upd.wr_tag  = 1'b1;
                upd.wr_cnt  = 1'b1;
                upd.cnt     = 8'd1;
                res.slot    = 5'(tok_tail.best_idx);
                res.need    = 1'b1;
                res.status  = STS_OK;
                res.cnt     = 8'd1;
            end
            else
            begin
                res.status = STS_NOFREE;
            end
        end
        else if (32'(tok_tail.slot) >= ENTRIES)
        begin
            res.slot   = tok_tail.slot;
            res.status = STS_NOFREE;
        end
        else
        begin
            upd.idx  = IDX_W'(tok_tail.slot);
            res.slot = tok_tail.slot;
            if (tok_tail.op == OP_PIN)
            begin
                upd.wr_cnt = (cnt != COUNT_MAX);
                upd.cnt    = cnt + 8'd1;
                res.status = (cnt == COUNT_MAX) ? STS_OVER : STS_OK;
                res.cnt    = (cnt == COUNT_MAX) ? COUNT_MAX : cnt + 8'd1;
            end
            else
            begin
                upd.wr_cnt   = (cnt != 8'd0);
                upd.cnt      = cnt - 8'd1;
                upd.wr_stamp = (tok_tail.op == OP_RELEASE) && (cnt == 8'd1);
                res.status   = (cnt == 8'd0) ? STS_UNDER : STS_OK;
                res.cnt      = (cnt == 8'd0) ? 8'd0 : cnt - 8'd1;
            end
        end
        upd.en = done && (upd.wr_cnt || upd.set_vld);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            out_vld_reg <= 1'b0;
            out_reg     <= '0;
            pend_reg    <= '0;
        end
        else
        begin
            if (out.ready)
            begin
                out_vld_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        state_reg <= S_SCAN;
                    end
                end
                S_SCAN:
                begin
                    if (done)
                    begin
                        if (out_free)
                        begin
                            out_reg     <= res;
                            out_vld_reg <= 1'b1;
                            state_reg   <= S_IDLE;
                        end
                        else
                        begin
                            pend_reg  <= res;
                            state_reg <= S_HOLD;
                        end
                    end
                end
                S_HOLD:
                begin
                    if (out_free)
                    begin
                        out_reg     <= pend_reg;
                        out_vld_reg <= 1'b1;
                        state_reg   <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign out.valid         = out_vld_reg;
    assign out.slot_out      = out_reg.slot;
    assign out.hit           = out_reg.hit;
    assign out.need_read     = out_reg.need;
    assign out.status        = out_reg.status;
    assign out.ref_count_out = out_reg.cnt;

endmodule

/* rtl/core/block_cache_lru_tag_table.sv */
// ----------------------------------------------------------------------------
// block_cache_lru_tag_table
// Disk block cache tag table with timestamp LRU replacement.
//
//   channel | dir | payload
//   --------+-----+------------------------------------------------------
//   in      | in  | opcode, device_id, block_number, slot_in, now_tick
//   out     | out | slot_out, hit, need_read, status, ref_count_out
//
// A request beat launches a token down a row of ENTRIES cells, one cell per
// cycle. The result is registered once the token leaves the last cell, and the
// next request beat can be taken in the same cycle as the result appears, so a
// new request is not taken before the previous one has passed the whole row.
// The update is written back to the chosen cell as the token leaves the row.
// A new request is taken as soon as the previous result sits in the output
// register, even if the sink stalls it there.
// Reset clears all entries at once; no clearing pass is needed.
// ----------------------------------------------------------------------------
module block_cache_lru_tag_table (
    input  logic   clk,
    input  logic   rst_n,
    blkc_in_if.sink    in,
    blkc_out_if.source out
);
    import blkc_pkg::*;

    tok_t tok [ENTRIES+1];
    upd_t upd;

    blkc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in       (in),
        .out      (out),
        .tok_head (tok[0]),
        .tok_tail (tok[ENTRIES]),
        .upd      (upd)
    );

    for (genvar i = 0; i < ENTRIES; i++)
    begin : g_cell
        blkc_cell u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .my_idx  (IDX_W'(i)),
            .tok_in  (tok[i]),
            .upd     (upd),
            .tok_out (tok[i+1])
        );
    end

endmodule

/* rtl/core/blkc_checker.sv */
// ----------------------------------------------------------------------------
// blkc_checker
// Port level checks of the tag table, bound to the top level.
// ----------------------------------------------------------------------------
module blkc_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_ready,
    input logic       out_valid,
    input logic       out_ready,
    input logic       hit,
    input logic       need_read,
    input logic [1:0] status,
    input logic [7:0] ref_count_out
);
    import blkc_pkg::*;

    // A result beat waits until the sink takes it.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result beat dropped while stalled");

    // Only one request is searched at a time.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("request taken while a search is running");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && hit |-> (status == STS_OK || status == STS_OVER))
        else $error("hit with bad status");

    // A filled slot always holds at least one reference.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && need_read |-> ref_count_out != 8'd0)
        else $error("read requested for unreferenced slot");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == STS_OVER |-> ref_count_out == COUNT_MAX)
        else $error("overflow without saturated count");

endmodule

bind block_cache_lru_tag_table blkc_checker u_blkc_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in.valid),
    .in_ready      (in.ready),
    .out_valid     (out.valid),
    .out_ready     (out.ready),
    .hit           (out.hit),
    .need_read     (out.need_read),
    .status        (out.status),
    .ref_count_out (out.ref_count_out)
);
